// ===== rtl/stbs_pkg.sv =====
package stbs_pkg;

    localparam int WORD_W        = 32;
    localparam int SLOT_W        = 10;
    localparam int COUNT_W       = 11;
    localparam int DEFAULT_DEPTH = 1024;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_PROBE,
        ST_CHECK,
        ST_PUSH
    } search_state_t;

endpackage

// ===== rtl/stbs_if.sv =====
interface stbs_req_if import stbs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [SLOT_W-1:0]        slot;
    logic signed [WORD_W-1:0] word;

    modport source (output valid, output mode, output slot, output word, input ready);
    modport sink (input valid, input mode, input slot, input word, output ready);
endinterface

interface stbs_rsp_if ();
    logic valid;
    logic ready;
    logic found;

    modport source (output valid, output found, input ready);
    modport sink (input valid, input found, output ready);
endinterface

// ===== rtl/stbs_table.sv =====
module stbs_table import stbs_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_DEPTH,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic signed [WORD_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr_a,
    input  logic [AW-1:0]            rd_addr_b,
    output logic signed [WORD_W-1:0] rd_data_a,
    output logic signed [WORD_W-1:0] rd_data_b
);

    logic signed [WORD_W-1:0] mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ===== rtl/sorted_table_binary_search_core.sv =====
// Sorted table binary search.
// req channel: mode selects load or query. A load writes word into slot and
// gives no item on rsp; slots at or beyond TABLE_DEPTH are dropped.
// A query searches the first entry_count slots, capped at TABLE_DEPTH, for word
// and gives one rsp item whose found bit says whether word is present. The
// table must be loaded in ascending signed order and only written slots may lie
// in the searched range. cfg_we/cfg_wdata set entry_count; write it only while
// the block is idle. One item is worked on at a time. A query runs one table
// read per probe on a dual-read synchronous memory: ST_STEP, then ST_PROBE for
// each further probe, ST_CHECK to compare and ST_PUSH; a load is accepted every
// cycle while the block is idle.
// rsp is registered: a new item is taken while a result waits, and a query that
// finishes while rsp is stalled holds its result until rsp is free.
// Reset clears entry_count to zero, the control state and rsp valid; the table
// content is undefined until written.
module sorted_table_binary_search_core import stbs_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    stbs_req_if.sink           req,
    stbs_rsp_if.source         rsp,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int NW  = (CW > COUNT_W) ? CW : COUNT_W;

    search_state_t            state_reg, state_next;
    logic [COUNT_W-1:0]       count_reg;
    logic signed [WORD_W-1:0] key_reg, key_next;
    logic [AW-1:0]            lo_reg, lo_next;
    logic [AW-1:0]            hi_reg, hi_next;
    logic [AW-1:0]            mid_reg, mid_next;
    logic                     empty_reg, empty_next;
    logic                     result_reg, result_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_found_reg, out_found_next;

    logic                     wr_en;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr_a, rd_addr_b;
    logic signed [WORD_W-1:0] rd_data_a, rd_data_b;

    logic [NW-1:0]            count_ext;
    logic [NW-1:0]            n_used;
    logic                     slot_ok;
    logic                     le;
    logic [AW-1:0]            cur_lo, cur_hi, cur_mid;
    logic [AW:0]              bound_sum;
    logic                     more;

    stbs_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (AW'(req.slot)),
        .wr_data   (req.word),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    assign count_ext = NW'(count_reg);
    assign n_used    = (count_ext > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : count_ext;
    assign slot_ok   = NW'(req.slot) < NW'(TABLE_DEPTH);

    // narrow the bounds with the probe that just returned
    assign le        = rd_data_a <= key_reg;
    assign cur_lo    = (state_reg == ST_PROBE && le) ? mid_reg : lo_reg;
    assign cur_hi    = (state_reg == ST_PROBE && !le) ? mid_reg : hi_reg;
    assign bound_sum = {1'b0, cur_lo} + {1'b0, cur_hi};
    assign cur_mid   = AW'(bound_sum >> 1);
    assign more      = ({1'b0, cur_lo} + (AW+1)'(1)) < {1'b0, cur_hi};

    assign rsp.valid = out_valid_reg;
    assign rsp.found = out_found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        empty_reg     <= empty_next;
        result_reg    <= result_next;
        out_found_reg <= out_found_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        empty_next     = empty_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_found_next = out_found_reg;
        req.ready      = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr_a      = cur_mid;
        rd_addr_b      = cur_hi;

        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    if (req.mode == MODE_QUERY)
                    begin
                        key_next   = req.word;
                        lo_next    = '0;
                        hi_next    = AW'(n_used - NW'(1));
                        empty_next = (n_used == '0);
                        state_next = ST_STEP;
                    end
                    else
                    begin
                        wr_en = slot_ok;
                    end
                end
            end
            ST_STEP, ST_PROBE:
            begin
                if (empty_reg)
                begin
                    result_next = 1'b0;
                    state_next  = ST_PUSH;
                end
                else
                begin
                    rd_en   = 1'b1;
                    lo_next = cur_lo;
                    hi_next = cur_hi;
                    if (more)
                    begin
                        mid_next   = cur_mid;
                        state_next = ST_PROBE;
                    end
                    else
                    begin
                        rd_addr_a  = cur_lo;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                result_next = (rd_data_a == key_reg) || (rd_data_b == key_reg);
                state_next  = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = result_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_probe_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> (({1'b0, lo_reg} + (AW+1)'(1)) < {1'b0, hi_reg}))
        else $error("probe issued with bounds already adjacent");

    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.mode == MODE_QUERY) |=> (state_reg == ST_STEP))
        else $error("accepted query did not start a search");

    a_empty_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && empty_reg) |=> (state_reg == ST_PUSH && !result_reg))
        else $error("empty table query did not report not found");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH && (!out_valid_reg || rsp.ready))
            |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result push lost");
`endif

endmodule

// ===== tb/sorted_table_binary_search_core_tb.sv =====
module sorted_table_binary_search_core_tb;
    import stbs_pkg::*;

    localparam int DEPTH       = DEFAULT_DEPTH;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 20;

    typedef struct packed {
        logic                     mode;
        logic [SLOT_W-1:0]        slot;
        logic signed [WORD_W-1:0] word;
    } req_item_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_wdata;

    stbs_req_if req_ch ();
    stbs_rsp_if rsp_ch ();

    sorted_table_binary_search_core #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    req_item_t                pending_reqs[$];
    bit                       expected_found[$];
    req_item_t                cur_item;
    logic signed [WORD_W-1:0] entry_words[DEPTH];
    logic [COUNT_W-1:0]       active_count;
    logic signed [WORD_W-1:0] gen_words[DEPTH];
    int                       cycle_count = 0;
    int                       errors      = 0;
    int                       n_loads     = 0;
    int                       n_queries   = 0;
    int                       n_results   = 0;
    int                       n_settings  = 0;
    int                       items_made  = 0;
    wire                      calm = (cycle_count % 3000) < 800;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results still due",
                     $time, cycle_count, expected_found.size());
            $display("sorted_table_binary_search_core_tb: FAIL");
            $finish;
        end
    end

    function automatic bit search_table(logic signed [WORD_W-1:0] key);
        int n;
        int lo;
        int hi;
        int mid;
        n = (active_count > DEPTH) ? DEPTH : int'(active_count);
        if (n == 0)
            return 1'b0;
        lo = 0;
        hi = n - 1;
        while (lo + 1 < hi)
        begin
            mid = (lo + hi) >> 1;
            if (entry_words[mid] <= key)
                lo = mid;
            else
                hi = mid;
        end
        return (entry_words[lo] == key) || (entry_words[hi] == key);
    endfunction

    // driver: predict on accept, then advance to the next pending item
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.mode  <= MODE_LOAD;
            req_ch.slot  <= '0;
            req_ch.word  <= '0;
            for (int i = 0; i < DEPTH; i++)
                entry_words[i] = '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                if (cur_item.mode == MODE_LOAD)
                begin
                    entry_words[cur_item.slot] = cur_item.word;
                    n_loads++;
                end
                else
                begin
                    expected_found = {expected_found, search_table(cur_item.word)};
                    n_queries++;
                end
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 15))
                begin
                    cur_item = pending_reqs.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.mode  <= cur_item.mode;
                    req_ch.slot  <= cur_item.slot;
                    req_ch.word  <= cur_item.word;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                n_results++;
                if (expected_found.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got found=%0b",
                             $time, rsp_ch.found);
                    errors++;
                end
                else
                begin
                    bit exp_found;
                    exp_found = expected_found.pop_front();
                    if (rsp_ch.found !== exp_found)
                    begin
                        $display("%0t: found mismatch, expected %0b, got %0b",
                                 $time, exp_found, rsp_ch.found);
                        errors++;
                    end
                end
            end
            rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 15);
        end
    end

    task automatic push_load(int slot, logic signed [WORD_W-1:0] word);
        req_item_t item;
        item.mode = MODE_LOAD;
        item.slot = SLOT_W'(slot);
        item.word = word;
        gen_words[slot] = word;
        pending_reqs = {pending_reqs, item};
        items_made++;
    endtask

    task automatic push_query(logic signed [WORD_W-1:0] key);
        req_item_t item;
        item.mode = MODE_QUERY;
        item.slot = SLOT_W'($urandom_range(0, DEPTH - 1));
        item.word = key;
        pending_reqs = {pending_reqs, item};
        items_made++;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || req_ch.valid || expected_found.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_count(int count);
        wait_idle();
        cfg_we       <= 1'b1;
        cfg_wdata    <= COUNT_W'(count);
        active_count = COUNT_W'(count);
        n_settings++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic fill_table(int n, bit sorted);
        int     order[DEPTH];
        int     i;
        int     j;
        int     tmp;
        longint step;
        longint room;
        longint v;
        if (sorted)
        begin
            step = ($urandom_range(0, 2) == 0) ? 64'sd2 : 64'sd4294967295 / (n + 1);
            room = 64'sd4294967296 - longint'(n) * step;
            if (room < 1)
                room = 1;
            v = longint'({32'd0, $urandom} % room) - 64'sd2147483648;
            for (i = 0; i < n; i++)
            begin
                v += $urandom_range(0, int'(step));
                gen_words[i] = v[WORD_W-1:0];
            end
            if ($urandom_range(0, 3) == 0)
                gen_words[0] = 32'sh8000_0000;
            if ($urandom_range(0, 3) == 0)
                gen_words[n-1] = 32'sh7fff_ffff;
        end
        else
        begin
            for (i = 0; i < n; i++)
                gen_words[i] = $urandom;
        end
        for (i = 0; i < n; i++)
            order[i] = i;
        for (i = n - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (i = 0; i < n; i++)
            push_load(order[i], gen_words[order[i]]);
    endtask

    // load ascending words on the leftmost and rightmost probe paths of a full table
    task automatic fill_edges();
        bit                       on_path[DEPTH];
        int                       lo;
        int                       hi;
        int                       mid;
        int                       i;
        logic signed [WORD_W-1:0] v;
        for (i = 0; i < DEPTH; i++)
            on_path[i] = 1'b0;
        lo = 0;
        hi = DEPTH - 1;
        while (lo + 1 < hi)
        begin
            mid          = (lo + hi) >> 1;
            on_path[mid] = 1'b1;
            hi           = mid;
        end
        on_path[lo] = 1'b1;
        on_path[hi] = 1'b1;
        lo = 0;
        hi = DEPTH - 1;
        while (lo + 1 < hi)
        begin
            mid          = (lo + hi) >> 1;
            on_path[mid] = 1'b1;
            lo           = mid;
        end
        on_path[lo] = 1'b1;
        on_path[hi] = 1'b1;
        v = -32'sd1000000 - WORD_W'($urandom_range(0, 1000000));
        for (i = 0; i < DEPTH; i++)
        begin
            if (on_path[i])
            begin
                v = v + WORD_W'($urandom_range(1, 1000));
                push_load(i, v);
            end
        end
    endtask

    // keys whose search stays on the loaded edge paths
    function automatic logic signed [WORD_W-1:0] pick_edge_key();
        case ($urandom_range(0, 6))
            0:       return gen_words[0];
            1:       return gen_words[0] - 1;
            2:       return gen_words[1] - 1;
            3:       return gen_words[DEPTH - 2];
            4:       return gen_words[DEPTH - 1];
            5:       return gen_words[DEPTH - 1] + 1;
            default: return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
        endcase
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_key(int n);
        if (n == 0)
            return $urandom;
        case ($urandom_range(0, 7))
            0, 1, 2: return gen_words[$urandom_range(0, n - 1)];
            3:       return gen_words[$urandom_range(0, n - 1)] + 1;
            4:       return gen_words[$urandom_range(0, n - 1)] - 1;
            5:       return $urandom;
            6:       return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
            default: return (n < DEPTH) ? gen_words[$urandom_range(n, DEPTH - 1)] : $urandom;
        endcase
    endfunction

    initial
    begin
        int round;
        int n;
        int count;
        int eff;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        active_count = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            gen_words[i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        @(negedge clk);
        push_load(0, 32'sh8000_0000);
        push_load(1, -32'sd5);
        push_load(2, 32'sd7);
        push_load(3, 32'sh7fff_ffff);
        push_load(DEPTH - 1, 32'sh5a5a_5a5a);
        set_count(0);
        push_query(32'sd7);
        push_query(32'sh8000_0000);
        set_count(1);
        push_query(32'sh8000_0000);
        push_query(32'sd7);
        set_count(2);
        push_query(-32'sd5);
        push_query(32'sh8000_0000);
        push_query(32'sd0);
        set_count(4);
        push_query(32'sh7fff_ffff);
        push_query(32'sh8000_0000);
        push_query(-32'sd5);
        push_query(32'sd7);
        push_query(32'sd6);
        push_query(32'sd8);
        push_query(32'sh5a5a_5a5a);

        round = 0;
        while (items_made < 730)
        begin
            round++;
            wait_idle();
            @(negedge clk);
            n = (round % 6 == 5) ? $urandom_range(1, 3) : $urandom_range(4, 48);
            fill_table(n, round % 4 != 3);
            repeat ($urandom_range(0, 3))
                push_load($urandom_range(n, DEPTH - 1), $urandom);
            if (round % 7 == 6)
                count = 0;
            else if ($urandom_range(0, 3) == 0)
                count = $urandom_range(1, n);
            else
                count = n;
            set_count(count);
            repeat ($urandom_range(12, 30))
            begin
                if ($urandom_range(0, 9) == 0)
                    push_load($urandom_range(n, DEPTH - 1), $urandom);
                else
                    push_query(pick_key(count));
            end
        end

        wait_idle();
        @(negedge clk);
        fill_edges();
        set_count(DEPTH);
        repeat (30) push_query(pick_edge_key());
        set_count((1 << COUNT_W) - 1);
        repeat (30) push_query(pick_edge_key());
        set_count($urandom_range(DEPTH + 1, (1 << COUNT_W) - 2));
        repeat (20) push_query(pick_edge_key());

        wait_idle();
        $display("covered %0d loads, %0d queries and %0d results over %0d count settings",
                 n_loads, n_queries, n_results, n_settings);
        $display("tables ran from empty to full-depth searches, sorted and unsorted, counts past depth");
        if (errors == 0)
            $display("sorted_table_binary_search_core_tb: PASS");
        else
            $display("sorted_table_binary_search_core_tb: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/stbs_pkg.sv
rtl/stbs_if.sv
rtl/stbs_table.sv
rtl/sorted_table_binary_search_core.sv
tb/sorted_table_binary_search_core_tb.sv
